/* src/ipv4dd_pkg.sv */
`timescale 1ns / 1ps

package ipv4dd_pkg;

    localparam int CHAR_W   = 8;
    localparam int ACC_W    = 9;
    localparam int IDX_W    = 2;
    localparam int ADDR_W   = 32;
    localparam int PART_W   = 24;
    localparam int STATUS_W = 2;

    localparam logic [ACC_W-1:0]  ACC_SAT    = 9'd256;
    localparam logic [IDX_W-1:0]  LAST_OCTET = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2e;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]  octet_index;
        logic [ACC_W-1:0]  octet_acc;
        logic [PART_W-1:0] partial_addr;
        logic              finished;
    } parse_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

/* src/ipv4dd_step.sv */
`timescale 1ns / 1ps

module ipv4dd_step (
    input  ipv4dd_pkg::parse_state_t          state_cur,
    input  logic [ipv4dd_pkg::CHAR_W-1:0]     ch,
    input  logic                              first,
    output ipv4dd_pkg::parse_state_t          state_next,
    output logic                              emit,
    output ipv4dd_pkg::result_t               result
);
    import ipv4dd_pkg::*;

    parse_state_t      st;
    logic              is_digit;
    logic              ends_octet;
    logic [3:0]        digit;
    logic [ACC_W+2:0]  acc_sum;   // acc*10 + digit, at most 2569

    always_comb begin
        // a first flag clears the parser before the character is looked at
        if (first) begin
            st.octet_index  = '0;
            st.octet_acc    = '0;
            st.partial_addr = '0;
            st.finished     = 1'b0;
        end else begin
            st = state_cur;
        end

        is_digit   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        digit      = 4'(ch - CHAR_ZERO);
        acc_sum    = ({3'b000, st.octet_acc} << 3) + ({3'b000, st.octet_acc} << 1)
                     + {8'd0, digit};
        ends_octet = ((st.octet_index != LAST_OCTET) && (ch == CHAR_DOT))
                     || (st.octet_index == LAST_OCTET);

        state_next     = st;
        emit           = 1'b0;
        result.address = '0;
        result.status  = STATUS_OK;

        priority if (st.finished) begin
            state_next = st;
        end else if (is_digit) begin
            state_next.octet_acc = (acc_sum >= {3'b000, ACC_SAT}) ? ACC_SAT
                                                                  : acc_sum[ACC_W-1:0];
        end else if (ends_octet) begin
            priority if (st.octet_acc >= ACC_SAT) begin
                emit                 = 1'b1;
                result.status        = STATUS_RANGE;
                state_next.finished  = 1'b1;
            end else if (st.octet_index == LAST_OCTET) begin
                emit                 = 1'b1;
                result.address       = {st.partial_addr, st.octet_acc[7:0]};
                state_next.finished  = 1'b1;
            end else begin
                state_next.partial_addr = {st.partial_addr[PART_W-9:0], st.octet_acc[7:0]};
                state_next.octet_index  = st.octet_index + 1'b1;
                state_next.octet_acc    = '0;
            end
        end else begin
            emit                = 1'b1;
            result.status       = STATUS_BAD_CHAR;
            state_next.finished = 1'b1;
        end
    end

endmodule

/* src/ipv4dd_out_reg.sv */
`timescale 1ns / 1ps

module ipv4dd_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  ipv4dd_pkg::result_t   load_data,
    output logic                  busy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ipv4dd_pkg::result_t   m_data
);
    import ipv4dd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // slot is free when empty or when the word leaves this cycle
    assign busy       = valid_reg && !m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* src/ipv4_dotted_decimal_parser.sv */
`timescale 1ns / 1ps

// Streaming dotted-decimal IPv4 parser.
// Input words carry one character each: s_tdata[7:0] is the byte, s_tuser
// flags the first character of a new address string and restarts the parser.
// Digits build each octet; a dot closes octets one to three, any non-digit
// closes the fourth. At most one result word goes out per string, when the
// fourth octet closes or on the first error, and later characters are
// dropped until the next first flag. A result word holds the address on
// m_tdata (first octet in bits 31:24, zero on error) and the status on
// m_tuser (0 ok, 1 bad character, 2 octet above 255).
// Throughput is one character per cycle unless the result register is held:
// the per-character work is one multiply-by-ten add and a few compares
// between the input register and the result register. An accepted closing
// character passes the input register, then the result register, before
// m_tvalid rises. With m_tready low and a result pending, the input register
// keeps one more character and s_tready drops until the result word is taken.
// Reset empties both registers, leaving the parser waiting for a first flag.
module ipv4_dotted_decimal_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] address
    output logic [1:0]  m_tuser    // [1:0] status
);
    import ipv4dd_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_ch_reg;
    logic              in_first_reg;

    parse_state_t      state_reg;
    parse_state_t      state_next;
    parse_state_t      state_step;

    logic              step_emit;
    result_t           step_result;
    logic              out_busy;
    logic              advance;
    result_t           out_data;

    assign advance       = in_valid_reg && !out_busy;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (in_valid_reg && !advance);
    assign state_next    = advance ? state_step : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            state_reg.octet_index  <= '0;
            state_reg.octet_acc    <= '0;
            state_reg.partial_addr <= '0;
            state_reg.finished     <= 1'b1;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg    <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    ipv4dd_step u_step (
        .state_cur  (state_reg),
        .ch         (in_ch_reg),
        .first      (in_first_reg),
        .state_next (state_step),
        .emit       (step_emit),
        .result     (step_result)
    );

    ipv4dd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && step_emit),
        .load_data (step_result),
        .busy      (out_busy),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = out_data.address;
    assign m_tuser = out_data.status;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ipv4dd_pkg::*;

    localparam int CHAR_TARGET = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] ch
    logic        s_tuser;   // [0] first
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] address
    logic [1:0]  m_tuser;   // [1:0] status

    ipv4_dotted_decimal_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // directed script row: typed rows carry their own answer
    typedef struct packed {
        logic [7:0]          ch;
        logic                first;
        logic                typed;
        logic                has_res;
        logic [ADDR_W-1:0]   address;
        logic [STATUS_W-1:0] status;
    } script_row_t;

    localparam int SCRIPT_LEN = 23;
    script_row_t script [SCRIPT_LEN] = '{
        // stray character right after reset is dropped
        '{8'h78,      1'b0, 1'b1, 1'b0, 32'h0, STATUS_OK},
        // "...255." : three empty octets, fourth closed by a dot
        '{CHAR_DOT,   1'b1, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_DOT,   1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_DOT,   1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{8'h32,      1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{8'h35,      1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{8'h35,      1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_DOT,   1'b0, 1'b1, 1'b1, 32'h0000_00ff, STATUS_OK},
        // "256." : first octet one past the top
        '{8'h32,      1'b1, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{8'h35,      1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{8'h36,      1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_DOT,   1'b0, 1'b1, 1'b1, 32'h0, STATUS_RANGE},
        // "9999x" : saturated octet, then a bad character
        '{CHAR_NINE,  1'b1, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_NINE,  1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_NINE,  1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_NINE,  1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{8'h78,      1'b0, 1'b1, 1'b1, 32'h0, STATUS_BAD_CHAR},
        // dropped after a result
        '{8'h78,      1'b0, 1'b1, 1'b0, 32'h0, STATUS_OK},
        // "...\0" : all empty, NUL closes the fourth octet
        '{CHAR_DOT,   1'b1, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_DOT,   1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{CHAR_DOT,   1'b0, 1'b0, 1'b0, 32'h0, STATUS_OK},
        '{8'h00,      1'b0, 1'b1, 1'b1, 32'h0, STATUS_OK},
        // top byte as the very first character
        '{8'hff,      1'b1, 1'b1, 1'b1, 32'h0, STATUS_BAD_CHAR}
    };

    // parser copy kept in step with accepted words
    logic [IDX_W-1:0]  st_idx  = '0;
    logic [ACC_W-1:0]  st_acc  = '0;
    logic [PART_W-1:0] st_part = '0;
    logic              st_done = 1'b1;

    result_t pending_results [$];

    int src_idle;
    int sink_idle;
    int mismatches;
    int cycles;
    int chars_sent;
    int chars_parsed;
    int n_ok;
    int n_bad_char;
    int n_range;

    function automatic bit parse_char(input logic [7:0] c, input logic f,
                                      output result_t r, output bit live);
        int v;
        r = '0;
        live = 1'b1;
        if (f) begin
            st_idx  = '0;
            st_acc  = '0;
            st_part = '0;
            st_done = 1'b0;
        end
        if (st_done) begin
            live = 1'b0;
            return 1'b0;
        end
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = int'(st_acc) * 10 + int'(c - CHAR_ZERO);
            st_acc = (v >= int'(ACC_SAT)) ? ACC_SAT : v[ACC_W-1:0];
            return 1'b0;
        end
        if ((st_idx != LAST_OCTET && c == CHAR_DOT) || st_idx == LAST_OCTET) begin
            if (st_acc >= ACC_SAT) begin
                st_done = 1'b1;
                r.status = STATUS_RANGE;
                return 1'b1;
            end
            if (st_idx == LAST_OCTET) begin
                st_done = 1'b1;
                r.address = {st_part, st_acc[7:0]};
                r.status = STATUS_OK;
                return 1'b1;
            end
            st_part = {st_part[PART_W-9:0], st_acc[7:0]};
            st_idx  = st_idx + 1'b1;
            st_acc  = '0;
            return 1'b0;
        end
        st_done = 1'b1;
        r.status = STATUS_BAD_CHAR;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("MISMATCH at %0t: %s: expected %h, got %h", $realtime, what, want, got);
        mismatches++;
    endtask

    // drives one word, waits for the handshake, then updates the prediction
    task automatic send_char(input logic [7:0] c, input logic f, input bit typed,
                             input bit typed_res, input result_t typed_want);
        result_t r;
        bit      has_res;
        bit      live;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= f;
        do @(posedge aclk); while (!s_tready);
        has_res = parse_char(c, f, r, live);
        chars_sent++;
        if (live)
            chars_parsed++;
        if (typed) begin
            if (typed_res)
                pending_results = {pending_results, typed_want};
        end else if (has_res) begin
            pending_results = {pending_results, r};
        end
    endtask

    task automatic send_string();
        logic [7:0] txt [$];
        string      digs;
        logic [7:0] c;
        int         k;
        int         cut;
        for (int o = 0; o < 4; o++) begin
            k = $urandom_range(99);
            if (k < 6)
                digs = "";
            else if (k < 12)
                digs = $sformatf("%0d", $urandom_range(256, 999));
            else if (k < 16)
                digs = $sformatf("%0d%0d", $urandom_range(1, 99999), $urandom_range(0, 999));
            else
                digs = $sformatf("%0d", $urandom_range(0, 255));
            if ($urandom_range(9) == 0)
                digs = {"0", digs};
            for (int i = 0; i < digs.len(); i++)
                txt = {txt, digs[i]};
            if (o < 3)
                txt = {txt, CHAR_DOT};
        end
        // fourth octet ends at any non-digit
        k = $urandom_range(99);
        if (k < 20) begin
            c = CHAR_DOT;
        end else if (k < 30) begin
            c = 8'h00;
        end else begin
            do c = 8'($urandom_range(255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
        end
        txt = {txt, c};
        if ($urandom_range(99) < 15)
            txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
        // cut short: the next string restarts the parser mid-way
        if ($urandom_range(99) < 8) begin
            cut = $urandom_range(txt.size() - 1);
            while (txt.size() > cut + 1)
                void'(txt.pop_back());
        end
        for (int i = 0; i < txt.size(); i++)
            send_char(txt[i], i == 0, 1'b0, 1'b0, '0);
        if ($urandom_range(99) < 20) begin
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++)
                send_char(8'($urandom_range(255)), $urandom_range(19) == 0, 1'b0, 1'b0, '0);
        end
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result word with nothing pending", 32'h0, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.address)
                    flag_mismatch("address", want.address, m_tdata);
                if (m_tuser !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(m_tuser));
            end
            case (m_tuser)
                STATUS_OK:       n_ok++;
                STATUS_BAD_CHAR: n_bad_char++;
                default:         n_range++;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        result_t want;
        int      phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        src_idle  = 23;
        sink_idle = 77;
        phase     = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            want.address = script[i].address;
            want.status  = script[i].status;
            send_char(script[i].ch, script[i].first, script[i].typed,
                      script[i].has_res, want);
        end

        chars_parsed = 0;
        while (chars_parsed < CHAR_TARGET) begin
            if (phase == 0 && chars_parsed >= CHAR_TARGET / 3) begin
                // hold off until the result side has drained
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                src_idle  = 77;
                sink_idle = 23;
                phase = 1;
            end else if (phase == 1 && chars_parsed >= 2 * CHAR_TARGET / 3) begin
                src_idle  = 0;
                sink_idle = 0;
                phase = 2;
            end
            send_string();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d characters (%0d after the directed rows reached the parser)",
                 chars_sent, chars_parsed);
        $display("Checked results: %0d ok, %0d bad character, %0d octet out of range",
                 n_ok, n_bad_char, n_range);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
